FILE: rtl/bitmap_glyph_row_renderer_core_assert.svh
// Assertion macros shared by the glyph row renderer modules.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef BITMAP_GLYPH_ROW_RENDERER_CORE_ASSERT_SVH
`define BITMAP_GLYPH_ROW_RENDERER_CORE_ASSERT_SVH

// property holds in the same cycle as its trigger
`define BGRR_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// property holds in the cycle after its trigger
`define BGRR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/bgrr_pkg.sv
// Package for the glyph row renderer: request codes, register indexes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgrr_pkg;

  localparam int STORE_BYTES = 65536;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  localparam logic [5:0] MAX_GLYPH_WIDTH  = 6'd32;
  localparam logic [5:0] MAX_GLYPH_HEIGHT = 6'd32;
  localparam logic [7:0] NEWLINE_CODE     = 8'd10;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_RENDER = 2'd1;
  localparam logic [1:0] REQ_SET    = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TOTAL  = 2'd2;
  localparam logic [1:0] CFG_WRAP   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_FETCH,
    S_DRAIN,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic set;
    logic newline;
    logic start;
    logic base;
    logic fetch;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic is_newline;
    logic h_zero;
    logic last_byte;
    logic last_row;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/bgrr_datapath.sv
// Datapath: config registers, cursor, font store, row assembly and result register.
// Depends on bgrr_pkg; driven by bgrr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module bgrr_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bgrr_pkg::cmd_t cmd,
  output bgrr_pkg::sts_t     sts,
  input  wire logic [63:0]   in_tdata,
  input  wire logic          cfg_wr,
  input  wire logic [1:0]    cfg_addr,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          out_tready,
  output logic               out_tvalid,
  output logic [63:0]        out_tdata,
  output logic               out_tlast
);
  import bgrr_pkg::*;

  logic [5:0]  glyph_width_r;
  logic [5:0]  glyph_height_r;
  logic [9:0]  glyph_total_r;
  logic [15:0] wrap_column_r;
  logic [15:0] cursor_x_r;
  logic [15:0] cursor_y_r;

  logic [7:0]  mem [STORE_BYTES];
  logic [7:0]  rd_data_r;
  logic        rd_pend_r;
  logic [1:0]  k_d_r;

  logic [7:0]          glyph_r;
  logic [7:0]          stride_r;
  logic [STORE_AW-1:0] addr_r;
  logic [1:0]          k_r;
  logic [4:0]          row_r;
  logic [31:0]         mask_r;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_last_r;

  logic [5:0]  w_sat;
  logic [5:0]  h_sat;
  logic [6:0]  w_round;
  logic [2:0]  lb;
  logic [7:0]  char_code;
  logic [31:0] placed;
  logic [31:0] mask_cmb;
  logic [31:0] wmask;
  logic [7:0]  rd_rev;
  logic        out_free;

  assign char_code = in_tdata[7:0];
  assign w_sat   = (glyph_width_r > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : glyph_width_r;
  assign h_sat   = (glyph_height_r > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : glyph_height_r;
  assign w_round = {1'b0, w_sat} + 7'd7;
  assign lb      = w_round[5:3];
  assign wmask   = w_sat[5] ? 32'hFFFF_FFFF : ((32'd1 << w_sat[4:0]) - 32'd1);
  assign out_free = !out_valid_r || out_tready;

  // pixels are stored MSB first
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rd_rev[b] = rd_data_r[7-b];
    end
    for (int l = 0; l < 4; l++) begin
      placed[8*l +: 8] = (rd_pend_r && (k_d_r == 2'(l))) ? rd_rev : 8'd0;
    end
  end

  assign mask_cmb = mask_r | placed;

  always_comb begin
    sts.is_newline = (char_code == NEWLINE_CODE);
    sts.h_zero     = (h_sat == 6'd0);
    sts.last_byte  = (({1'b0, k_r} + 3'd1) >= lb);
    sts.last_row   = (({1'b0, row_r} + 6'd1) == h_sat);
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= 6'd8;
      glyph_height_r <= 6'd16;
      glyph_total_r  <= 10'd256;
      wrap_column_r  <= 16'd0;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        CFG_WIDTH:  glyph_width_r  <= cfg_data[5:0];
        CFG_HEIGHT: glyph_height_r <= cfg_data[5:0];
        CFG_TOTAL:  glyph_total_r  <= cfg_data[9:0];
        CFG_WRAP:   wrap_column_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= 16'd0;
      cursor_y_r <= 16'd0;
    end else begin
      priority if (cmd.set) begin
        cursor_x_r <= in_tdata[47:32];
        cursor_y_r <= in_tdata[63:48];
      end else if (cmd.newline) begin
        cursor_x_r <= wrap_column_r;
        cursor_y_r <= cursor_y_r + {10'd0, h_sat};
      end else if (cmd.advance) begin
        cursor_x_r <= cursor_x_r + {10'd0, w_sat};
      end
    end
  end

  // font store, single port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_tdata[8 +: STORE_AW]] <= in_tdata[31:24];
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    stride_r <= 8'(h_sat * lb);
    if (cmd.fetch) begin
      k_d_r <= k_r;
    end
    if (cmd.start) begin
      glyph_r <= ({2'd0, char_code} < glyph_total_r) ? char_code : 8'd0;
    end
    if (cmd.base) begin
      addr_r <= STORE_AW'({8'd0, glyph_r} * {8'd0, stride_r});
      k_r    <= 2'd0;
      row_r  <= 5'd0;
      mask_r <= 32'd0;
    end else begin
      if (cmd.fetch) begin
        addr_r <= addr_r + STORE_AW'(1);
        k_r    <= k_r + 2'd1;
      end
      if (cmd.emit) begin
        k_r    <= 2'd0;
        row_r  <= row_r + 5'd1;
        mask_r <= 32'd0;
      end else begin
        mask_r <= mask_cmb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {mask_cmb & wmask, cursor_y_r + {11'd0, row_r}, cursor_x_r};
      out_last_r <= sts.last_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/bgrr_ctrl.sv
// Controller state machine: decodes requests and sequences font reads per scanline.
// Depends on bgrr_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_glyph_row_renderer_core_assert.svh"

module bgrr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic [1:0]    in_tuser,
  output logic               in_tready,
  output bgrr_pkg::cmd_t     cmd,
  input  wire bgrr_pkg::sts_t sts
);
  import bgrr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            REQ_LOAD: cmd.load = 1'b1;
            REQ_SET:  cmd.set  = 1'b1;
            REQ_RENDER: begin
              priority if (sts.is_newline) begin
                cmd.newline = 1'b1;
              end else if (sts.h_zero) begin
                cmd.advance = 1'b1;
              end else begin
                cmd.start = 1'b1;
                state_nxt = S_SETUP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        cmd.base  = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.last_byte) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN, S_WAIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_row) begin
            cmd.advance = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `BGRR_ASSERT_NEXT(a_last_row_ends, cmd.emit && sts.last_row, state_r == S_IDLE, "render did not end after last row")
  `BGRR_ASSERT_SAME(a_drain_after_fetch, state_r == S_DRAIN, $past(state_r) == S_FETCH, "drain without fetch")
  `BGRR_ASSERT_NEXT(a_setup_to_fetch, state_r == S_SETUP, state_r == S_FETCH, "setup not followed by fetch")
  `BGRR_ASSERT_SAME(a_emit_needs_slot, cmd.emit, sts.out_free, "result register overwritten")

endmodule

`default_nettype wire

FILE: rtl/bitmap_glyph_row_renderer_core.sv
// Glyph row renderer top level: input, result and configuration channels.
// Instantiates bgrr_ctrl and bgrr_datapath; depends on bgrr_pkg.
//
// Input channel (in_*): one request per transaction, kind in in_tuser.
//   Loads, cursor sets and newlines complete without leaving the idle state.
//   A render reads B = ceil(width/8) bytes for each of H scanlines
//   (one read even at width zero): the font store has one read port,
//   one byte per cycle. After a setup step each scanline is fetched,
//   then drained, folding the last byte into the row mask; the drain
//   waits while the result register is still full.
// Result channel (out_*): one transaction per scanline, tlast on the last.
//   A registered output stage holds a row while the receiver stalls; the
//   next scanline is fetched meanwhile and waits until the register frees.
// Configuration (cfg_*): always ready; write only while the block is idle.
// Reset: cursor cleared, glyph 8x16, 256 glyphs, wrap column 0. The font
//   store is not cleared and must be loaded before it is rendered from.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_glyph_row_renderer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // char_code, store_address, store_byte, new_x, new_y
  input  wire logic [1:0]  in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // row_x, row_y, row_bits
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);
  import bgrr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  bgrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bgrr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_wr),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: verif/bitmap_glyph_row_renderer_core_tb.sv
// Self-checking testbench for bitmap_glyph_row_renderer_core: loads a font, renders
// glyphs under several geometries and checks every scanline against a local predictor.
// Depends on bgrr_pkg and the renderer RTL only.
`timescale 1ns / 1ps

module bitmap_glyph_row_renderer_core_tb;
  import bgrr_pkg::*;

  localparam int          CLK_HALF       = 2;
  localparam int          RESET_CYCLES   = 5;
  localparam int          PRELOAD_BYTES  = 128;
  localparam int          SEGMENTS       = 9;
  localparam int          ITEMS_PER_SEG  = 4;
  localparam int          SETTLE_CYCLES  = 200;
  localparam int          QUIET_LIMIT    = 4000;
  localparam int          MAX_PRINTED    = 50;
  localparam logic [1:0]  REQ_NONE       = 2'd3;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] bits;
    logic        last;
  } glyph_row_t;

  typedef struct packed {
    logic        to_reg;
    logic [1:0]  kind;
    logic [63:0] data;
    logic        pinned;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] pbits;
  } plan_step_t;

  // tdata: char_code[7:0] store_address[23:8] store_byte[31:24] new_x[47:32] new_y[63:48]
  localparam plan_step_t PLAN [31] = '{
    '{1'b0, REQ_RENDER, 64'h01, 1'b1, 16'h0000, 16'h0000, 32'h0000_00FF},
    '{1'b0, REQ_RENDER, 64'h02, 1'b1, 16'h0008, 16'h0000, 32'h0000_0080},
    '{1'b0, REQ_RENDER, 64'h0A, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_SET, 64'h7FFF_7FFF_0000_0000, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h07, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_SET, 64'h8000_8000_0000_0000, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h00, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_LOAD, 64'h0000_0000_FFFF_FF00, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_LOAD, 64'h0000_0000_A500_0000, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h00, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_WRAP, 64'h8000, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_TOTAL, 64'd1, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_WIDTH, 64'd32, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_HEIGHT, 64'd32, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'hFF, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h0A, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_WIDTH, 64'd0, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_HEIGHT, 64'd0, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_TOTAL, 64'd0, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h07, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h0A, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_HEIGHT, 64'd1, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h09, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_WIDTH, 64'd63, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_HEIGHT, 64'd63, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_TOTAL, 64'd31, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b1, CFG_WRAP, 64'h7FFF, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h00, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h0A, 1'b0, 16'h0, 16'h0, 32'h0},
    '{1'b0, REQ_RENDER, 64'h1F, 1'b0, 16'h0, 16'h0, 32'h0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = REQ_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr   = CFG_WIDTH;
  logic [15:0] cfg_data   = '0;

  // local copy of the block's state
  logic [7:0]  font_mem [0:STORE_BYTES-1];
  bit          written  [0:STORE_BYTES-1];
  logic [15:0] cur_x     = '0;
  logic [15:0] cur_y     = '0;
  logic [5:0]  reg_w     = 6'd8;
  logic [5:0]  reg_h     = 6'd16;
  logic [9:0]  reg_total = 10'd256;
  logic [15:0] reg_wrap  = '0;

  glyph_row_t  rows_due [$];
  bit          pin_on = 1'b0;
  logic [15:0] pin_x, pin_y;
  logic [31:0] pin_bits;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;

  bitmap_glyph_row_renderer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned eff_width();
    return (reg_w > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : reg_w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = reg_h;
    if (h > MAX_GLYPH_HEIGHT) h = MAX_GLYPH_HEIGHT;
    if (h > 32) h = 32;
    return h;
  endfunction

  function automatic int unsigned glyph_base(logic [7:0] code, int unsigned h, int unsigned lb);
    int unsigned g;
    g = 0;
    if (code < reg_total) g = code;
    return g * h * lb;
  endfunction

  // true when every byte the glyph would read has been loaded
  function automatic bit glyph_loaded(logic [7:0] code);
    int unsigned h, lb, base, k;
    h    = eff_height();
    lb   = (eff_width() + 7) / 8;
    base = glyph_base(code, h, lb);
    for (k = 0; k < h * lb; k++) begin
      if (!written[16'(base + k)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_request(logic [1:0] kind, logic [63:0] d);
    glyph_row_t  row;
    logic [7:0]  code, pix_byte;
    logic [15:0] addr;
    int unsigned w, h, lb, base, j, i;
    code = d[7:0];
    case (kind)
      REQ_LOAD: begin
        addr           = d[23:8];
        font_mem[addr] = d[31:24];
        written[addr]  = 1'b1;
      end
      REQ_SET: begin
        cur_x = d[47:32];
        cur_y = d[63:48];
      end
      REQ_RENDER: begin
        w  = eff_width();
        h  = eff_height();
        lb = (w + 7) / 8;
        if (code == NEWLINE_CODE) begin
          cur_x = reg_wrap;
          cur_y = cur_y + 16'(h);
        end else begin
          base = glyph_base(code, h, lb);
          for (j = 0; j < h; j++) begin
            row.bits = '0;
            for (i = 0; i < w; i++) begin
              pix_byte    = font_mem[16'(base + j * lb + i / 8)];
              row.bits[i] = pix_byte[7 - i % 8];
            end
            if (pin_on) row.bits = pin_bits;
            row.x    = pin_on ? pin_x : cur_x;
            row.y    = (pin_on ? pin_y : cur_y) + 16'(j);
            row.last = (j + 1 == h);
            rows_due.push_back(row);
          end
          cur_x = cur_x + 16'(w);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("%0t ns: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // handshakes are sampled at the falling edge, before the edge that completes them
  task automatic send_req(input logic [1:0] kind, input logic [63:0] d);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(negedge clk); while (!in_tready);
    predict_request(kind, d);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  reg_w     = val[5:0];
      CFG_HEIGHT: reg_h     = val[5:0];
      CFG_TOTAL:  reg_total = val[9:0];
      default:    reg_wrap  = val;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // waits until every predicted row has been taken, then lets the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    glyph_row_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (rows_due.size() == 0) begin
        report_mismatch($sformatf("row with nothing due: %h", out_tdata));
      end else begin
        due = rows_due.pop_front();
        if (out_tdata[15:0] !== due.x)
          report_mismatch($sformatf("row_x %h, want %h", out_tdata[15:0], due.x));
        if (out_tdata[31:16] !== due.y)
          report_mismatch($sformatf("row_y %h, want %h", out_tdata[31:16], due.y));
        if (out_tdata[63:32] !== due.bits)
          report_mismatch($sformatf("row_bits %h, want %h", out_tdata[63:32], due.bits));
        if (out_tlast !== due.last)
          report_mismatch($sformatf("last_row %b, want %b", out_tlast, due.last));
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] d;
    logic [1:0]  kind;
    int unsigned pick, tries, seg, sent, a;
    bit          big;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // font image: glyph 1 solid and glyph 2 a single rightmost pixel at 8x16, rest random;
    // covers glyph 0 at any geometry
    for (a = 0; a < PRELOAD_BYTES; a++) begin
      d        = '0;
      d[23:8]  = a[15:0];
      d[31:24] = (a >= 16 && a < 32) ? 8'hFF : (a >= 32 && a < 48) ? 8'h01 : 8'($urandom);
      send_req(REQ_LOAD, d);
    end

    foreach (PLAN[n]) begin
      if (PLAN[n].to_reg) begin
        wait_idle();
        write_reg(PLAN[n].kind, PLAN[n].data[15:0]);
      end else begin
        pin_on   = PLAN[n].pinned;
        pin_x    = PLAN[n].px;
        pin_y    = PLAN[n].py;
        pin_bits = PLAN[n].pbits;
        send_req(PLAN[n].kind, PLAN[n].data);
        pin_on   = 1'b0;
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0:       begin send_gap_pct = 9;  recv_stall_pct = 46; end
        1:       begin send_gap_pct = 46; recv_stall_pct = 9;  end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      wait_idle();
      big = (seg % 3 == 2);
      write_reg(CFG_WIDTH,  big ? 16'($urandom_range(9, 63)) : 16'($urandom_range(1, 8)));
      write_reg(CFG_HEIGHT, big ? 16'($urandom_range(17, 63)) : 16'($urandom_range(1, 16)));
      write_reg(CFG_TOTAL,  16'($urandom_range(1, 1023)));
      write_reg(CFG_WRAP,   16'($urandom));
      sent = 0;
      while (sent < ITEMS_PER_SEG) begin
        d    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 20) begin
          kind = REQ_LOAD;
          if ($urandom_range(1)) d[23:8] = 16'($urandom_range(PRELOAD_BYTES - 1));
        end else if (pick < 30) begin
          kind = REQ_SET;
        end else if (pick < 40) begin
          kind    = REQ_RENDER;
          d[7:0]  = NEWLINE_CODE;
        end else if (pick < 45) begin
          kind = REQ_NONE;
        end else begin
          kind  = REQ_RENDER;
          tries = 0;
          while (!glyph_loaded(d[7:0]) && tries < 4) begin
            d[7:0] = 8'($urandom);
            tries++;
          end
          if (!glyph_loaded(d[7:0])) d[7:0] = 8'd0;
        end
        send_req(kind, d);
        if (kind != REQ_NONE) sent++;
      end
    end

    wait_idle();
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
